// ===== src/iopt_pkg.sv =====
`timescale 1ns / 1ps

package iopt_pkg;

    // field width of position, item_count and prefix_length
    localparam int unsigned FIELD_W = 11;

    // default depth of the arrival map
    localparam int unsigned MAX_POSITIONS_DEF = 1024;

    // item_count after reset
    localparam logic [FIELD_W-1:0] ITEM_COUNT_RESET = 11'd1024;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK
    } t_state;

    // write control towards the arrival map
    typedef struct packed {
        logic wr_en;
        logic wr_bit;
    } t_map_ctrl;

endpackage

// ===== src/iopt_map.sv =====
`timescale 1ns / 1ps

module iopt_map
    import iopt_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF,
    localparam int unsigned AW = $clog2(MAX_POSITIONS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_map_ctrl     i_ctrl,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [AW-1:0] i_rd_addr,
    output logic          o_rd_bit,
    output logic          o_clearing
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    logic          r_mem [MAX_POSITIONS];
    logic          r_rd_bit;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // sweep every entry to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // write port: the sweep takes priority
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctrl.wr_bit;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rd_bit <= r_mem[i_rd_addr];
    end

    assign o_rd_bit   = r_rd_bit;
    assign o_clearing = r_clearing;

endmodule

// ===== src/in_order_prefix_tracker_core.sv =====
`timescale 1ns / 1ps

// In-order prefix tracker: records arrivals of positions 1..item_count given
// in any order and reports the longest run 1..k that has fully arrived.
// Input: a position is taken at a clock edge with start high and busy low.
// Output: one result per input, shown for one cycle with o_done high; the
// receiver cannot stall, so every result must be taken as it appears.
// Configuration: item_count is written through i_cfg_valid/o_cfg_ready,
// always ready; write it only while the block is idle.
// After the accepting edge, a bad position is answered in the next cycle; a
// repeated one after the map read in the check state; a new arrival after the
// check state marks it and the walk state advances the commit pointer over the
// arrived positions. The pointer walks one map entry per cycle through the
// single-bit arrival memory. The next position can be taken in the cycle its
// result shows; each position is walked over once.
// Reset: the arrival map is cleared by a sweep over all MAX_POSITIONS entries
// after reset; busy stays high until it ends. The pointer returns to zero and
// item_count to 1024.

module in_order_prefix_tracker_core
    import iopt_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] i_position,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [FIELD_W-1:0] i_cfg_data,
    output logic               o_done,
    output logic [FIELD_W-1:0] o_prefix_length,
    output logic               o_bad_position,
    output logic               o_repeated
);

    localparam int unsigned AW = $clog2(MAX_POSITIONS);
    localparam int unsigned PW = $clog2(MAX_POSITIONS + 1);

    t_state             r_state, n_state;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_pos, n_pos;
    logic               r_fwd, n_fwd;
    logic               r_done, n_done;
    logic               r_bad, n_bad;
    logic               r_rep, n_rep;
    logic [FIELD_W-1:0] r_prefix, n_prefix;
    logic [FIELD_W-1:0] r_item_count;

    t_map_ctrl          w_ctrl;
    logic [AW-1:0]      w_rd_addr;
    logic               w_rd_bit;
    logic               w_clearing;
    logic               w_accept;
    logic               w_bad;
    logic [AW-1:0]      w_pos_addr;
    logic               w_ptr_in_range;

    iopt_map #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_wr_addr (r_pos),
        .i_rd_addr (w_rd_addr),
        .o_rd_bit  (w_rd_bit),
        .o_clearing(w_clearing)
    );

    // configuration transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= ITEM_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_item_count <= i_cfg_data;
        end
    end

    // input transfer and range check against the clamped limit
    assign busy       = w_clearing || (r_state != ST_IDLE);
    assign w_accept   = start && !busy;
    assign w_bad      = (i_position == '0)
                     || (32'(i_position) > 32'(r_item_count))
                     || (32'(i_position) > MAX_POSITIONS);
    assign w_pos_addr = AW'(32'(i_position) - 32'd1);

    // pointer may step only while below the limit
    assign w_ptr_in_range = (32'(r_ptr) < 32'(r_item_count))
                         && (32'(r_ptr) < MAX_POSITIONS);

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_done  <= 1'b0;
            r_bad   <= 1'b0;
            r_rep   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_done  <= n_done;
            r_bad   <= n_bad;
            r_rep   <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_fwd    <= n_fwd;
        r_prefix <= n_prefix;
    end

    // sequencer: check, mark, then walk the pointer
    always_comb begin
        n_state       = r_state;
        n_ptr         = r_ptr;
        n_pos         = r_pos;
        n_fwd         = r_fwd;
        n_done        = 1'b0;
        n_bad         = 1'b0;
        n_rep         = 1'b0;
        n_prefix      = r_prefix;
        w_ctrl.wr_en  = 1'b0;
        w_ctrl.wr_bit = 1'b1;
        w_rd_addr     = w_pos_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_bad) begin
                        n_done   = 1'b1;
                        n_bad    = 1'b1;
                        n_prefix = FIELD_W'(r_ptr);
                    end else begin
                        n_pos   = w_pos_addr;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (w_rd_bit) begin
                    // already arrived: drop it
                    n_done   = 1'b1;
                    n_rep    = 1'b1;
                    n_prefix = FIELD_W'(r_ptr);
                    n_state  = ST_IDLE;
                end else begin
                    // mark and fetch the entry under the pointer, forwarding the mark
                    w_ctrl.wr_en = 1'b1;
                    w_rd_addr    = r_ptr[AW-1:0];
                    n_fwd        = (r_ptr[AW-1:0] == r_pos);
                    n_state      = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_ptr_in_range && (w_rd_bit || r_fwd)) begin
                    // advance over an arrived entry
                    n_ptr     = r_ptr + 1'b1;
                    w_rd_addr = n_ptr[AW-1:0];
                    n_fwd     = 1'b0;
                end else begin
                    n_done   = 1'b1;
                    n_prefix = FIELD_W'(r_ptr);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done          = r_done;
    assign o_prefix_length = r_prefix;
    assign o_bad_position  = r_bad;
    assign o_repeated      = r_rep;

`ifndef SYNTHESIS
    // a bad position is answered in the next cycle
    a_bad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_bad) |=> (o_done && o_bad_position))
        else $error("bad position not answered in the next cycle");

    // the commit pointer never moves back
    a_ptr_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_ptr >= $past(r_ptr)))
        else $error("commit pointer moved back");

    // a repeated result only follows a map check
    a_rep_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_repeated |-> ($past(r_state == ST_CHECK) && !o_bad_position))
        else $error("repeated flag without a map check");
`endif

endmodule
